@@ hdl/lea128ks_pkg.sv @@
package lea128ks_pkg;

	localparam int unsigned ROUND_COUNT_DEF = 24;
	localparam int unsigned ROUND_W = 5;
	localparam int unsigned WORD_W = 32;
	localparam int unsigned KEY_WORDS = 4;
	localparam int unsigned IN_TDATA_W = 128;
	localparam int unsigned OUT_TDATA_W = 136;

	localparam logic [WORD_W-1:0] LEA_DELTA [KEY_WORDS] = '{
		32'hc3efe9db, 32'h44626b02, 32'h79e27c8a, 32'h78df30ec
	};

	typedef struct packed {
		logic               advance;
		logic               load;
		logic [ROUND_W-1:0] round;
		logic               last;
	} ks_cmd_t;

	typedef struct packed {
		logic out_free;
	} ks_stat_t;

	function automatic logic [WORD_W-1:0] rotl_var(input logic [WORD_W-1:0] x,
			input logic [ROUND_W-1:0] n);
		logic [2*WORD_W-1:0] d;
		d = {x, x} << n;
		return d[2*WORD_W-1:WORD_W];
	endfunction

	function automatic logic [WORD_W-1:0] bswap(input logic [WORD_W-1:0] x);
		return {x[7:0], x[15:8], x[23:16], x[31:24]};
	endfunction

	// Round constant for word j of round i: delta[i mod 4] rotated left by i + j.
	function automatic logic [WORD_W-1:0] round_const(input logic [ROUND_W-1:0] i,
			input logic [1:0] j);
		logic [ROUND_W-1:0] amt;
		amt = i + {{(ROUND_W-2){1'b0}}, j};
		return rotl_var(LEA_DELTA[i[1:0]], amt);
	endfunction

endpackage

@@ hdl/lea128_key_schedule_unit.sv @@
// LEA-128 key schedule unit.
// A 128-bit key enters on the s_axis channel as four 32-bit words, key word 0 in
// the lowest bits. Each word is byte-swapped inside before use.
// For every key the unit sends ROUND_COUNT round keys on the m_axis channel, in
// round order. Each item carries the round number and the four updated words,
// and tlast marks the final round.
// One round is computed per cycle while the output is free, by a single round
// unit that works on the four words in parallel. Round 0 is computed in the
// cycle the key is accepted, and its registered result is valid in the next cycle.
// A key occupies the unit until its last round has been computed; the next key
// is accepted only after the controller has returned to idle, so the unit takes
// no new key while one is still being expanded.
// When the receiver holds m_axis_tready low, the current round waits in the
// output register and the schedule pauses; nothing is lost or repeated.
// Reset clears the controller and the output valid flag; the unit then waits
// for a key with s_axis_tready high.
module lea128_key_schedule_unit #(
	parameter int unsigned ROUND_COUNT = lea128ks_pkg::ROUND_COUNT_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// key_word_0, key_word_1, key_word_2, key_word_3
	input  logic [lea128ks_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// round_index, round_key_0, round_key_1, round_key_2, round_key_3, zero pad
	output logic [lea128ks_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	output logic                                 m_axis_tlast
);

	lea128ks_pkg::ks_cmd_t  cmd;
	lea128ks_pkg::ks_stat_t stat;

	lea128ks_ctrl #(
		.ROUND_COUNT(ROUND_COUNT)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	lea128ks_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.key_data  (s_axis_tdata),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule

@@ hdl/lea128ks_datapath.sv @@
module lea128ks_datapath (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  lea128ks_pkg::ks_cmd_t                    cmd,
	output lea128ks_pkg::ks_stat_t                   stat,
	input  logic [lea128ks_pkg::IN_TDATA_W-1:0]      key_data,
	output logic                                     out_valid,
	input  logic                                     out_ready,
	output logic [lea128ks_pkg::OUT_TDATA_W-1:0]     out_data,
	output logic                                     out_last
);

	logic [lea128ks_pkg::WORD_W-1:0] t_q [lea128ks_pkg::KEY_WORDS];
	logic [lea128ks_pkg::WORD_W-1:0] src [lea128ks_pkg::KEY_WORDS];
	logic [lea128ks_pkg::WORD_W-1:0] sum [lea128ks_pkg::KEY_WORDS];
	logic [lea128ks_pkg::WORD_W-1:0] t_next [lea128ks_pkg::KEY_WORDS];
	logic                               out_valid_q;
	logic                               out_last_q;
	logic [lea128ks_pkg::ROUND_W-1:0]   out_round_q;
	logic [lea128ks_pkg::WORD_W-1:0]    out_key_q [lea128ks_pkg::KEY_WORDS];

	always_comb begin
		for (int j = 0; j < lea128ks_pkg::KEY_WORDS; j++) begin
			if (cmd.load) begin
				src[j] = lea128ks_pkg::bswap(key_data[j*lea128ks_pkg::WORD_W +:
					lea128ks_pkg::WORD_W]);
			end else begin
				src[j] = t_q[j];
			end
			sum[j] = src[j] + lea128ks_pkg::round_const(cmd.round, 2'(j));
		end
		t_next[0] = {sum[0][30:0], sum[0][31]};
		t_next[1] = {sum[1][28:0], sum[1][31:29]};
		t_next[2] = {sum[2][25:0], sum[2][31:26]};
		t_next[3] = {sum[3][20:0], sum[3][31:21]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			for (int j = 0; j < lea128ks_pkg::KEY_WORDS; j++) begin
				t_q[j] <= '0;
			end
		end else begin
			if (cmd.advance) begin
				out_valid_q <= 1'b1;
				for (int j = 0; j < lea128ks_pkg::KEY_WORDS; j++) begin
					t_q[j] <= t_next[j];
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.advance) begin
			out_round_q <= cmd.round;
			out_last_q  <= cmd.last;
			for (int j = 0; j < lea128ks_pkg::KEY_WORDS; j++) begin
				out_key_q[j] <= t_next[j];
			end
		end
	end

	assign stat.out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_last  = out_last_q;
	assign out_data  = {3'b000, out_key_q[3], out_key_q[2], out_key_q[1], out_key_q[0],
		out_round_q};

endmodule

@@ hdl/lea128ks_ctrl.sv @@
module lea128ks_ctrl #(
	parameter int unsigned ROUND_COUNT = lea128ks_pkg::ROUND_COUNT_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  lea128ks_pkg::ks_stat_t stat,
	output lea128ks_pkg::ks_cmd_t  cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	localparam logic [lea128ks_pkg::ROUND_W-1:0] LAST_ROUND =
		lea128ks_pkg::ROUND_W'(ROUND_COUNT - 1);

	state_t                           state_q;
	logic [lea128ks_pkg::ROUND_W-1:0] round_q;

	always_comb begin
		in_ready    = (state_q == ST_IDLE) && stat.out_free;
		cmd.load    = (state_q == ST_IDLE);
		cmd.round   = (state_q == ST_IDLE) ? '0 : round_q;
		cmd.last    = (cmd.round == LAST_ROUND);
		cmd.advance = stat.out_free && ((state_q == ST_RUN) || in_valid);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			round_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.advance && !cmd.last) begin
						state_q <= ST_RUN;
						round_q <= lea128ks_pkg::ROUND_W'(1);
					end
				end
				ST_RUN: begin
					if (cmd.advance) begin
						if (cmd.last) begin
							state_q <= ST_IDLE;
						end else begin
							round_q <= round_q + lea128ks_pkg::ROUND_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ tb/tb_lea128_key_schedule_unit.sv @@
`timescale 1ns / 1ps
module tb_lea128_key_schedule_unit;

	localparam int unsigned ROUNDS = lea128ks_pkg::ROUND_COUNT_DEF;
	localparam logic [31:0] KS_DELTA [4] = '{
		32'hc3efe9db, 32'h44626b02, 32'h79e27c8a, 32'h78df30ec
	};
	localparam int WORD_SHIFT [4] = '{1, 3, 6, 11};

	typedef struct packed {
		logic [lea128ks_pkg::ROUND_W-1:0]     index;
		logic [3:0][lea128ks_pkg::WORD_W-1:0] words;
		logic                                 last;
	} round_keys_t;

	class round_key_board;
		round_keys_t pending_rounds[$];
		int errors;
		int keys_seen;
		int rounds_checked;

		function new();
			errors = 0;
			keys_seen = 0;
			rounds_checked = 0;
		endfunction

		task report(input string what);
			$display("mismatch at %0t: %s", $time, what);
			errors++;
		endtask

		function logic [31:0] rol(input logic [31:0] x, input int n);
			int m;
			m = n % 32;
			if (m == 0)
				return x;
			return (x << m) | (x >> (32 - m));
		endfunction

		// Expands one accepted key into its full run of round keys.
		function void note_key(input logic [lea128ks_pkg::IN_TDATA_W-1:0] key);
			logic [31:0] t [4];
			logic [31:0] w;
			round_keys_t r;
			for (int j = 0; j < 4; j++) begin
				w = key[32*j +: 32];
				t[j] = {w[7:0], w[15:8], w[23:16], w[31:24]};
			end
			for (int i = 0; i < ROUNDS; i++) begin
				for (int j = 0; j < 4; j++)
					t[j] = rol(t[j] + rol(KS_DELTA[i % 4], i + j), WORD_SHIFT[j]);
				r.index = i[lea128ks_pkg::ROUND_W-1:0];
				for (int j = 0; j < 4; j++)
					r.words[j] = t[j];
				r.last = (i == ROUNDS - 1);
				pending_rounds.push_back(r);
			end
			keys_seen++;
		endfunction

		task check_round(input logic [lea128ks_pkg::OUT_TDATA_W-1:0] data, input logic last);
			round_keys_t want;
			if (pending_rounds.size() == 0) begin
				report($sformatf("round %0d arrived with nothing pending", data[4:0]));
				return;
			end
			want = pending_rounds.pop_front();
			rounds_checked++;
			if (data[4:0] !== want.index)
				report($sformatf("round index %0d, want %0d", data[4:0], want.index));
			for (int j = 0; j < 4; j++)
				if (data[5 + 32*j +: 32] !== want.words[j])
					report($sformatf("round %0d word %0d is %h, want %h", want.index, j,
						data[5 + 32*j +: 32], want.words[j]));
			if (last !== want.last)
				report($sformatf("round %0d tlast %b, want %b", want.index, last, want.last));
		endtask
	endclass

	logic                                 clk = 1'b0;
	logic                                 arst_n = 1'b0;
	logic                                 key_valid = 1'b0;
	logic [lea128ks_pkg::IN_TDATA_W-1:0]  key_data = '0;
	logic                                 round_ready = 1'b1;
	logic                                 s_axis_tready;
	logic                                 m_axis_tvalid;
	logic [lea128ks_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
	logic                                 m_axis_tlast;
	logic                                 calm = 1'b0;
	int                                   stall_left = 0;
	round_key_board                       board;

	lea128_key_schedule_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(key_valid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(key_data),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(round_ready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

	always #1 clk = ~clk;

	initial begin
		#2000000;
		$display("timeout at %0t", $time);
		$display("tb_lea128_key_schedule_unit: errors");
		$finish;
	end

	initial begin
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && round_ready)
				board.check_round(m_axis_tdata, m_axis_tlast);
			if (stall_left > 0) begin
				stall_left--;
				if (stall_left == 0)
					round_ready <= 1'b1;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 13);
				round_ready <= 1'b0;
			end
		end
	end

	task automatic send_key(input logic [lea128ks_pkg::IN_TDATA_W-1:0] key);
		key_valid <= 1'b1;
		key_data <= key;
		do @(posedge clk); while (!s_axis_tready);
		board.note_key(key);
		if (!calm && $urandom_range(0, 2) == 0) begin
			key_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
	endtask

	task automatic drain_rounds();
		key_valid <= 1'b0;
		while (board.pending_rounds.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [31:0] random_word();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		logic [lea128ks_pkg::IN_TDATA_W-1:0] corner_keys [12];
		logic [lea128ks_pkg::IN_TDATA_W-1:0] key;
		corner_keys = '{
			'0,
			'1,
			128'h0f1e2d3c_4b5a6978_8796a5b4_c3d2e1f0,
			{4{32'h55555555}},
			{4{32'haaaaaaaa}},
			128'h1,
			128'h8000_0000_0000_0000_0000_0000_0000_0000,
			128'h00000080_00008000_00800000_80000000,
			128'h000000ff_0000ff00_00ff0000_ff000000,
			128'hffffffff_00000000_ffffffff_00000000,
			128'h01234567_89abcdef_fedcba98_76543210,
			{4{32'h80000001}}
		};
		board = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (corner_keys[n])
			send_key(corner_keys[n]);
		for (int n = 0; n < 170; n++) begin
			if (n == 70)
				drain_rounds();
			if (n == 140)
				calm = 1'b1;
			key = {random_word(), random_word(), random_word(), random_word()};
			send_key(key);
		end
		drain_rounds();
		repeat (3 * ROUNDS) @(posedge clk);
		$display("%0d keys expanded, %0d round keys compared, with random stalls on",
			board.keys_seen, board.rounds_checked);
		$display("both sides, corner keys first and a full drain part way through.");
		if (board.errors == 0) begin
			$display("tb_lea128_key_schedule_unit: clean");
		end else begin
			$display("tb_lea128_key_schedule_unit: errors");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/lea128ks_pkg.sv
hdl/lea128ks_datapath.sv
hdl/lea128ks_ctrl.sv
hdl/lea128_key_schedule_unit.sv
tb/tb_lea128_key_schedule_unit.sv
